@@ rtl/core/sxf_pkg.sv @@
// Shared types and constants for the sprite XOR framebuffer.
// No dependencies; imported by every module of the block.
`default_nettype none

package sxf_pkg;

	localparam int SCREEN_COLS_DEF  = 64;
	localparam int SCREEN_LINES_DEF = 32;
	localparam int SPRITE_W         = 8;
	localparam int PIX_W            = 64;
	localparam int IN_TDATA_W       = 32;
	localparam int IN_TUSER_W       = 2;
	localparam int OUT_TDATA_W      = 72;
	localparam int XPOS_W           = 8;
	localparam int YPOS_W           = 8;
	localparam int RIDX_W           = 4;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_DRAW  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} fsm_t;

	// merged result of all sprite lanes
	typedef struct packed {
		logic hit;
	} merge_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/sprite_xor_framebuffer.sv @@
// Top level of the sprite XOR framebuffer: sequencer, coordinate wrap, lanes, merge.
// Depends on sxf_pkg, sxf_lane, sxf_merge, sxf_row_store.
//
// channel  | dir | handshake                    | payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: x_pos,y_pos,row_index,sprite_row,first_row
//          |     |                              | tuser: action
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: collision,row_pixels
//
// Each item is accepted in ST_IDLE, which reads the target row from the row memory;
// ST_EXEC, once the output register is free, runs the eight lanes and writes the row back (one memory port each way).
// Clear goes through the same states: it drops the per-row valid bits at once.
// Reset clears the valid bits and the collision flag; no clearing pass is needed.
// A result waits in the output register; the next item is accepted once the current
// one has moved its result there.
`default_nettype none

module sprite_xor_framebuffer #(
	parameter int SCREEN_COLS  = sxf_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_LINES = sxf_pkg::SCREEN_LINES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [7:0] x_pos, [15:8] y_pos, [19:16] row_index, [27:20] sprite_row, [28] first_row
	input  wire logic [sxf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// [1:0] action
	input  wire logic [sxf_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [0] collision, [64:1] row_pixels
	output logic      [sxf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import sxf_pkg::*;

	localparam int CW        = $clog2(SCREEN_COLS);
	localparam int LW        = (SCREEN_LINES > 1) ? $clog2(SCREEN_LINES) : 1;
	localparam int OUT_SHIFT = PIX_W - SCREEN_COLS;

	// wrap tables, built at elaboration
	logic [CW-1:0] xmod_tab [2**XPOS_W];
	logic [LW-1:0] ymod_tab [2**YPOS_W];
	logic [LW-1:0] rmod_tab [2**RIDX_W];

	for (genvar i = 0; i < 2**XPOS_W; i++) begin : g_xtab
		assign xmod_tab[i] = CW'(i % SCREEN_COLS);
	end
	for (genvar i = 0; i < 2**YPOS_W; i++) begin : g_ytab
		assign ymod_tab[i] = LW'(i % SCREEN_LINES);
	end
	for (genvar i = 0; i < 2**RIDX_W; i++) begin : g_rtab
		assign rmod_tab[i] = LW'(i % SCREEN_LINES);
	end

	// input unpack
	logic [XPOS_W-1:0]   in_x;
	logic [YPOS_W-1:0]   in_y;
	logic [RIDX_W-1:0]   in_ri;
	logic [SPRITE_W-1:0] in_sprite;
	logic                in_first;
	action_t             in_act;

	assign in_x      = s_axis_tdata[7:0];
	assign in_y      = s_axis_tdata[15:8];
	assign in_ri     = s_axis_tdata[19:16];
	assign in_sprite = s_axis_tdata[27:20];
	assign in_first  = s_axis_tdata[28];
	assign in_act    = action_t'(s_axis_tuser);

	fsm_t state_q, state_nx;
	logic in_fire;
	logic out_fire;
	logic go;

	// registered item
	action_t             act_q;
	logic                first_q;
	logic [SPRITE_W-1:0] sprite_q;
	logic [CW-1:0]       xmod_q;
	logic [LW-1:0]       line_q;
	logic                hit_q;

	logic                out_valid_q;
	logic                out_coll_q;
	logic [PIX_W-1:0]    out_pix_q;

	logic [LW:0]         line_sum;
	logic [LW-1:0]       line_acc;
	logic [LW-1:0]       rd_addr;

	logic [SCREEN_COLS-1:0] rd_data;
	logic [SCREEN_COLS-1:0] new_word;
	logic [SCREEN_COLS-1:0] flips [SPRITE_W];
	logic [SPRITE_W-1:0]    hits;
	merge_stat_t            mstat;

	logic wr_en;
	logic clr;
	logic load;
	logic hit_nx;

	assign in_fire  = s_axis_tvalid & s_axis_tready;
	assign out_fire = m_axis_tvalid & m_axis_tready;
	assign go       = (state_q == ST_EXEC) & (~out_valid_q | m_axis_tready);

	// target row: draw adds the sprite row index, read uses y alone
	always_comb begin
		if (in_act == ACT_DRAW) begin
			line_sum = {1'b0, ymod_tab[in_y]} + {1'b0, rmod_tab[in_ri]};
		end else begin
			line_sum = {1'b0, ymod_tab[in_y]};
		end
		if (line_sum >= (LW+1)'(SCREEN_LINES)) begin
			line_acc = LW'(line_sum - (LW+1)'(SCREEN_LINES));
		end else begin
			line_acc = line_sum[LW-1:0];
		end
		rd_addr = line_acc;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q    <= in_act;
			first_q  <= in_first;
			sprite_q <= in_sprite;
			xmod_q   <= xmod_tab[in_x];
			line_q   <= line_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		s_axis_tready = 1'b0;
		wr_en         = 1'b0;
		clr           = 1'b0;
		load          = 1'b0;
		hit_nx        = hit_q;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (go) begin
					load     = 1'b1;
					state_nx = ST_IDLE;
					unique case (act_q)
						ACT_CLEAR: clr = 1'b1;
						ACT_DRAW: begin
							wr_en  = 1'b1;
							hit_nx = (hit_q & ~first_q) | mstat.hit;
						end
						ACT_READ: ;
						ACT_NONE: ;
						default: ;
					endcase
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			hit_q <= hit_nx;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_coll_q <= hit_nx;
			out_pix_q  <= (act_q == ACT_READ) ? (PIX_W'(rd_data) << OUT_SHIFT) : '0;
		end
	end

	for (genvar k = 0; k < SPRITE_W; k++) begin : g_lane
		sxf_lane #(
			.SCREEN_COLS (SCREEN_COLS),
			.LANE        (k)
		) u_lane (
			.x_base (xmod_q),
			.pix_en (sprite_q[SPRITE_W-1-k]),
			.word   (rd_data),
			.flip   (flips[k]),
			.hit    (hits[k])
		);
	end

	sxf_merge #(
		.SCREEN_COLS (SCREEN_COLS)
	) u_merge (
		.word     (rd_data),
		.flips    (flips),
		.hits     (hits),
		.new_word (new_word),
		.stat     (mstat)
	);

	sxf_row_store #(
		.SCREEN_COLS  (SCREEN_COLS),
		.SCREEN_LINES (SCREEN_LINES)
	) u_rows (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (line_q),
		.wr_data (new_word),
		.clr     (clr)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W-PIX_W-1)'(0), out_pix_q, out_coll_q};

endmodule

`default_nettype wire

@@ rtl/core/sxf_lane.sv @@
// One sprite-pixel lane: wraps its column and tests/flips one framebuffer bit.
// Depends on sxf_pkg.
`default_nettype none

module sxf_lane #(
	parameter int SCREEN_COLS = sxf_pkg::SCREEN_COLS_DEF,
	parameter int LANE        = 0
) (
	input  wire logic [$clog2(SCREEN_COLS)-1:0] x_base,
	input  wire logic                           pix_en,
	input  wire logic [SCREEN_COLS-1:0]         word,
	output logic      [SCREEN_COLS-1:0]         flip,
	output logic                                hit
);
	import sxf_pkg::*;

	localparam int CW = $clog2(SCREEN_COLS);
	localparam logic [SCREEN_COLS-1:0] LEFT_BIT = SCREEN_COLS'(1) << (SCREEN_COLS - 1);

	logic [CW:0] col_sum;
	logic [CW:0] col;

	always_comb begin
		col_sum = {1'b0, x_base} + (CW+1)'(LANE);
		// base is already below the width, so one subtract wraps
		if (col_sum >= (CW+1)'(SCREEN_COLS)) begin
			col = col_sum - (CW+1)'(SCREEN_COLS);
		end else begin
			col = col_sum;
		end
		flip = pix_en ? (LEFT_BIT >> col) : '0;
		hit  = |(word & flip);
	end

endmodule

`default_nettype wire

@@ rtl/core/sxf_merge.sv @@
// Merge stage: ORs the lane flip masks and hits, builds the new row word.
// Depends on sxf_pkg.
`default_nettype none

module sxf_merge #(
	parameter int SCREEN_COLS = sxf_pkg::SCREEN_COLS_DEF
) (
	input  wire logic [SCREEN_COLS-1:0]   word,
	input  wire logic [SCREEN_COLS-1:0]   flips [sxf_pkg::SPRITE_W],
	input  wire logic [sxf_pkg::SPRITE_W-1:0] hits,
	output logic      [SCREEN_COLS-1:0]   new_word,
	output sxf_pkg::merge_stat_t          stat
);
	import sxf_pkg::*;

	logic [SCREEN_COLS-1:0] mask;

	always_comb begin
		mask = '0;
		for (int k = 0; k < SPRITE_W; k++) begin
			mask = mask | flips[k];
		end
		// lanes hit distinct columns, so OR of masks equals their XOR
		new_word     = word ^ mask;
		stat.hit     = |hits;
	end

endmodule

`default_nettype wire

@@ rtl/core/sxf_row_store.sv @@
// Framebuffer row memory with one valid bit per row; invalid rows read as zero.
// Depends on sxf_pkg.
`default_nettype none

module sxf_row_store #(
	parameter int SCREEN_COLS  = sxf_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_LINES = sxf_pkg::SCREEN_LINES_DEF,
	localparam int LW = (SCREEN_LINES > 1) ? $clog2(SCREEN_LINES) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   rd_en,
	input  wire logic [LW-1:0]          rd_addr,
	output logic      [SCREEN_COLS-1:0] rd_data,
	input  wire logic                   wr_en,
	input  wire logic [LW-1:0]          wr_addr,
	input  wire logic [SCREEN_COLS-1:0] wr_data,
	input  wire logic                   clr
);
	import sxf_pkg::*;

	logic [SCREEN_COLS-1:0]  mem_q [SCREEN_LINES];
	logic [SCREEN_COLS-1:0]  rd_word_q;
	logic                    rd_ok_q;
	logic [SCREEN_LINES-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	// reset drops the valid bits and the read-valid flag; clear just drops the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_ok_q ? rd_word_q : '0;

endmodule

`default_nettype wire

@@ rtl/core/sxf_checker.sv @@
// Port-level checks for the sprite XOR framebuffer, bound to the top level.
// Depends on sxf_pkg and sprite_xor_framebuffer.
`default_nettype none

module sxf_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [sxf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import sxf_pkg::*;

	// a stalled result stays and holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one item at a time: no input transfer right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an item is in work");

	// a new result only ever follows a cycle with the input closed
	a_rise_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without an item in work");

	// padding bits above the row are zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:PIX_W+1] == '0)
		else $error("output padding not zero");

endmodule

bind sprite_xor_framebuffer sxf_checker u_sxf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/sprite_xor_framebuffer_test.sv @@
// Self-checking testbench for sprite_xor_framebuffer: directed and random stream traffic.
// Depends on sxf_pkg and the sprite_xor_framebuffer RTL; the screen predictor is built in.
`timescale 1ns / 1ps

module sprite_xor_framebuffer_test;
	import sxf_pkg::*;

	localparam int COLS  = SCREEN_COLS_DEF;
	localparam int LINES = SCREEN_LINES_DEF;

	typedef struct {
		logic        collision;
		logic [63:0] row_pixels;
	} fb_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// predicted screen contents and collision flag
	logic [63:0] screen_img [LINES];
	logic        collision_flag;
	fb_result_t  expected_results [$];
	int          error_count = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;

	sprite_xor_framebuffer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin : clock_gen
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Apply one item to the screen image and return what the block should report.
	function automatic fb_result_t apply_to_screen(action_t act, logic [7:0] x, logic [7:0] y,
			logic [3:0] ri, logic [7:0] spr, logic first);
		fb_result_t  res;
		int          line;
		int          col;
		logic [63:0] word;
		logic [63:0] mask;
		res.row_pixels = '0;
		case (act)
			ACT_CLEAR: begin
				for (int r = 0; r < LINES; r++)
					screen_img[r] = '0;
			end
			ACT_DRAW: begin
				line = (int'(y) + int'(ri)) % LINES;
				word = screen_img[line];
				if (first)
					collision_flag = 1'b0;
				for (int k = 0; k < 8; k++) begin
					if (spr[7-k]) begin
						col = (int'(x) + k) % COLS;
						mask = 64'd1 << (63 - col);
						if ((word & mask) != 0)
							collision_flag = 1'b1;
						word ^= mask;
					end
				end
				screen_img[line] = word;
			end
			ACT_READ: res.row_pixels = screen_img[int'(y) % LINES];
			default: ;
		endcase
		res.collision = collision_flag;
		return res;
	endfunction

	// Present one item, hold it until the transfer, then record the prediction.
	task automatic send_item(action_t act, logic [7:0] x, logic [7:0] y, logic [3:0] ri,
			logic [7:0] spr, logic first);
		int unsigned gap;
		gap = tx_idle_on ? $urandom_range(0, 18) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {3'b000, first, spr, ri, y, x};
		s_axis_tuser  = act;
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(apply_to_screen(act, x, y, ri, spr, first));
	endtask

	initial begin : result_sink
		int unsigned stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_idle_on ? $urandom_range(0, 18) : 0;
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		fb_result_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: tdata %h", m_axis_tdata);
				error_count++;
			end else begin
				exp_res = expected_results.pop_front();
				if (m_axis_tdata[0] !== exp_res.collision) begin
					$error("collision: expected %0d, got %0d", exp_res.collision,
						m_axis_tdata[0]);
					error_count++;
				end
				if (m_axis_tdata[64:1] !== exp_res.row_pixels) begin
					$error("row_pixels: expected %h, got %h", exp_res.row_pixels,
						m_axis_tdata[64:1]);
					error_count++;
				end
			end
		end
	end

	task automatic test_reset_state();
		send_item(ACT_READ, 8'd0, 8'd0, 4'd0, 8'd0, 1'b0);
		send_item(ACT_READ, 8'hff, 8'd31, 4'hf, 8'hff, 1'b1);
	endtask

	task automatic test_collision();
		send_item(ACT_DRAW, 8'd0, 8'd0, 4'd0, 8'hff, 1'b1);
		send_item(ACT_DRAW, 8'd4, 8'd0, 4'd0, 8'hf0, 1'b0);   // erases lit pixels
		send_item(ACT_DRAW, 8'd20, 8'd1, 4'd0, 8'h81, 1'b0);  // flag stays sticky
		send_item(ACT_READ, 8'd0, 8'd0, 4'd0, 8'd0, 1'b1);    // first_row ignored on read
		send_item(ACT_DRAW, 8'd20, 8'd1, 4'd0, 8'h00, 1'b1);  // new sprite restarts flag
		send_item(ACT_READ, 8'd0, 8'd1, 4'd0, 8'd0, 1'b0);
	endtask

	task automatic test_draw_wrap();
		send_item(ACT_DRAW, 8'd60, 8'd5, 4'd0, 8'hff, 1'b1);  // right edge
		send_item(ACT_DRAW, 8'd255, 8'd5, 4'd1, 8'h80, 1'b0);
		send_item(ACT_DRAW, 8'd63, 8'd31, 4'd15, 8'h01, 1'b0); // bottom edge
		send_item(ACT_DRAW, 8'd128, 8'd255, 4'd15, 8'h5a, 1'b0);
		send_item(ACT_READ, 8'd0, 8'd5, 4'd0, 8'd0, 1'b0);
		send_item(ACT_READ, 8'd0, 8'd6, 4'd0, 8'd0, 1'b0);
		send_item(ACT_READ, 8'd0, 8'd14, 4'd0, 8'd0, 1'b0);
		send_item(ACT_READ, 8'd0, 8'd255, 4'd0, 8'd0, 1'b0);
	endtask

	task automatic test_clear_and_spare_action();
		send_item(ACT_DRAW, 8'd0, 8'd14, 4'd0, 8'h01, 1'b1);  // new sprite restarts flag, no hit
		send_item(ACT_NONE, 8'hff, 8'hff, 4'hf, 8'hff, 1'b1);
		send_item(ACT_CLEAR, 8'hff, 8'hff, 4'hf, 8'hff, 1'b1); // flag kept over clear
		send_item(ACT_READ, 8'd0, 8'd14, 4'd0, 8'd0, 1'b0);
		send_item(ACT_NONE, 8'd0, 8'd0, 4'd0, 8'd0, 1'b0);
		send_item(ACT_DRAW, 8'd0, 8'd14, 4'd0, 8'hff, 1'b0);
	endtask

	// Mostly whole sprites with random content, plus reads, clears and noise.
	task automatic test_random_sprites(int n_items);
		int          sent;
		int unsigned pick;
		int unsigned rows;
		logic [7:0]  x;
		logic [7:0]  y;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 39) == 0) begin
				tx_idle_on = 1'($urandom_range(0, 1));
				rx_idle_on = 1'($urandom_range(0, 1));
			end
			pick = $urandom_range(0, 99);
			x = 8'($urandom_range(0, 255));
			y = 8'($urandom_range(0, 255));
			if (pick < 65) begin
				rows = $urandom_range(1, 16);
				for (int r = 0; r < rows; r++)
					send_item(ACT_DRAW, x, y, 4'(r), 8'($urandom_range(0, 255)),
						r == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0));
				sent += rows;
			end else begin
				if (pick < 85)
					send_item(ACT_READ, x, y, 4'($urandom_range(0, 15)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				else if (pick < 87)
					send_item(ACT_CLEAR, x, y, 4'($urandom_range(0, 15)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				else if (pick < 90)
					send_item(ACT_NONE, x, y, 4'($urandom_range(0, 15)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				else
					send_item(action_t'($urandom_range(0, 3)), x, y,
						4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	task automatic test_back_to_back();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int i = 0; i < 60; i++)
			send_item(i % 3 == 2 ? ACT_READ : ACT_DRAW, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			error_count++;
		end
	endtask

	initial begin : main_seq
		for (int r = 0; r < LINES; r++)
			screen_img[r] = '0;
		collision_flag = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_collision();
		test_draw_wrap();
		test_clear_and_spare_action();
		test_random_sprites(1150);
		test_back_to_back();
		drain_results();

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/sxf_pkg.sv
rtl/core/sxf_lane.sv
rtl/core/sxf_merge.sv
rtl/core/sxf_row_store.sv
rtl/core/sprite_xor_framebuffer.sv
rtl/core/sxf_checker.sv
tb/sprite_xor_framebuffer_test.sv
